// File: design/fsv_pkg.sv
// shared types and constants for the fasta stream validator
package fsv_pkg;

  localparam logic [7:0] NlByte      = 8'h0A;
  localparam logic [7:0] HdrByte     = 8'h3E;
  localparam logic [7:0] CaseMask    = 8'hDF;
  localparam logic [7:0] BaseA       = 8'h41;
  localparam logic [7:0] BaseC       = 8'h43;
  localparam logic [7:0] BaseG       = 8'h47;
  localparam logic [7:0] BaseT       = 8'h54;
  localparam logic [7:0] BaseN       = 8'h4E;
  localparam logic [7:0] LenMax      = 8'hFF;
  localparam logic [7:0] MaxLenReset = 8'd80;

  localparam logic KindName = 1'b0;
  localparam logic KindBase = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic       char_valid;
    logic       char_kind;
    logic [7:0] char_value;
    logic       record_end;
    logic       format_error;
    logic       file_accepted;
  } out_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic       is_nl;
    logic       is_hdr;
    logic       is_base;
    logic [7:0] raw;
    logic       last;
  } cls_t;

endpackage

// File: design/fsv_front.sv
// front end: classifies each incoming byte
module fsv_front (
  input  fsv_pkg::in_t  in_data_i,
  output fsv_pkg::cls_t cls_o
);

  logic [7:0] folded;

  assign folded = in_data_i.data_byte & fsv_pkg::CaseMask;

  always_comb begin
    cls_o.is_nl   = (in_data_i.data_byte == fsv_pkg::NlByte);
    cls_o.is_hdr  = (in_data_i.data_byte == fsv_pkg::HdrByte);
    // folding keeps bit 7, so only plain ascii letters match
    cls_o.is_base = (folded == fsv_pkg::BaseA) || (folded == fsv_pkg::BaseC) ||
                    (folded == fsv_pkg::BaseG) || (folded == fsv_pkg::BaseT) ||
                    (folded == fsv_pkg::BaseN);
    cls_o.raw     = in_data_i.data_byte;
    cls_o.last    = in_data_i.last_byte;
  end

endmodule

// File: design/fsv_fifo.sv
// two-entry queue between front and back
module fsv_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  fsv_pkg::cls_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output fsv_pkg::cls_t pop_data_o
);

  fsv_pkg::cls_t mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o     = (cnt_q == 2'd2);
  assign empty_o    = (cnt_q == 2'd0);
  assign pop_data_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/fsv_back.sv
// back end: line and record tracking, error detection, output register
module fsv_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [7:0]    max_len_i,
  input  logic          cls_valid_i,
  input  fsv_pkg::cls_t cls_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fsv_pkg::out_t out_data_o
);

  logic       start_q, start_d;
  logic       hdr_q, hdr_d;
  logic [7:0] len_q, len_d;
  logic       rec_q, rec_d;
  logic       failed_q, failed_d;
  logic       out_valid_q, out_valid_d;
  fsv_pkg::out_t out_q, res;

  logic       err;
  logic [7:0] bumped;

  assign pop_o       = cls_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign bumped      = (len_q == fsv_pkg::LenMax) ? len_q : len_q + 8'd1;

  always_comb begin
    start_d  = start_q;
    hdr_d    = hdr_q;
    len_d    = len_q;
    rec_d    = rec_q;
    failed_d = failed_q;
    err      = 1'b0;
    res      = '0;

    if (!failed_q) begin
      if (start_q) begin
        if (cls_i.is_nl) begin
          err = 1'b1;
        end else if (cls_i.is_hdr) begin
          res.record_end = rec_q;
          rec_d   = 1'b1;
          hdr_d   = 1'b1;
          len_d   = 8'd1;
          start_d = 1'b0;
          if (cls_i.last) err = 1'b1;
        end else if (cls_i.is_base) begin
          if (!rec_q) begin
            err = 1'b1;
          end else begin
            hdr_d   = 1'b0;
            len_d   = 8'd1;
            start_d = 1'b0;
            if (max_len_i == 8'd0) err = 1'b1;
            res.char_valid = 1'b1;
            res.char_kind  = fsv_pkg::KindBase;
            res.char_value = cls_i.raw & fsv_pkg::CaseMask;
          end
        end else begin
          err = 1'b1;
        end
      end else if (cls_i.is_nl) begin
        // header with no name, or header line that ends the file
        if (hdr_q && (len_q == 8'd1 || cls_i.last)) err = 1'b1;
        start_d = 1'b1;
        len_d   = 8'd0;
      end else if (hdr_q) begin
        len_d = bumped;
        res.char_valid = 1'b1;
        res.char_kind  = fsv_pkg::KindName;
        res.char_value = cls_i.raw;
        if (cls_i.last) err = 1'b1;
      end else if (!cls_i.is_base) begin
        err = 1'b1;
      end else begin
        len_d = bumped;
        if (bumped > max_len_i) err = 1'b1;
        res.char_valid = 1'b1;
        res.char_kind  = fsv_pkg::KindBase;
        res.char_value = cls_i.raw & fsv_pkg::CaseMask;
      end

      if (!err && cls_i.last) begin
        res.record_end    = 1'b1;
        res.file_accepted = 1'b1;
      end
      if (err) begin
        res              = '0;
        res.format_error = 1'b1;
        failed_d         = 1'b1;
      end
    end

    // end of file brings everything back for the next file
    if (cls_i.last) begin
      start_d  = 1'b1;
      hdr_d    = 1'b0;
      len_d    = 8'd0;
      rec_d    = 1'b0;
      failed_d = 1'b0;
    end

    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q     <= 1'b1;
      hdr_q       <= 1'b0;
      len_q       <= 8'd0;
      rec_q       <= 1'b0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        start_q  <= start_d;
        hdr_q    <= hdr_d;
        len_q    <= len_d;
        rec_q    <= rec_d;
        failed_q <= failed_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= res;
    end
  end

endmodule

// File: design/fasta_stream_validator_core.sv
// top level of the fasta stream validator
// path: each byte is written into the queue, then its result is registered in the back-end output register
// throughput: one byte per cycle while the output side is not stalled, set by the line/record update in the back end
// the two-entry queue and the output register let either side stall; a full queue takes no byte, even while popped
// reset: all line and record state cleared, queue emptied, max_line_length back to 80
module fasta_stream_validator_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fsv_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fsv_pkg::out_t out_data_o,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_wdata_i
);

  logic [7:0]    max_len_q;
  fsv_pkg::cls_t cls_in, cls_head;
  logic          full, empty, push, pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= fsv_pkg::MaxLenReset;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = !full;
  assign push       = in_valid_i && !full;

  fsv_front u_front (
    .in_data_i (in_data_i),
    .cls_o     (cls_in)
  );

  fsv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (cls_in),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (cls_head)
  );

  fsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .max_len_i   (max_len_q),
    .cls_valid_i (!empty),
    .cls_i       (cls_head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: design/fsv_checker.sv
// port-level checks for the fasta stream validator, bound to the top level
module fsv_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input fsv_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input fsv_pkg::out_t out_data_o,
  input logic          cfg_we_i,
  input logic [7:0]    cfg_wdata_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // an error beat carries nothing else
  a_err_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.format_error |->
      !out_data_o.char_valid && !out_data_o.record_end && !out_data_o.file_accepted)
    else $error("error beat carries other flags");

  // empty char slot is all zero
  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.char_valid |->
      out_data_o.char_kind == fsv_pkg::KindName && out_data_o.char_value == 8'd0)
    else $error("char fields set without char_valid");

  // a base leaves in upper case
  a_base_upper: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.char_valid && out_data_o.char_kind == fsv_pkg::KindBase |->
      out_data_o.char_value == fsv_pkg::BaseA || out_data_o.char_value == fsv_pkg::BaseC ||
      out_data_o.char_value == fsv_pkg::BaseG || out_data_o.char_value == fsv_pkg::BaseT ||
      out_data_o.char_value == fsv_pkg::BaseN)
    else $error("base not in upper case");

  // an accepted file always closes its record
  a_acc_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.file_accepted |-> out_data_o.record_end)
    else $error("file accepted without record end");

endmodule

bind fasta_stream_validator_core fsv_checker u_fsv_checker (.*);
